[src/pptw_pkg.sv]
// pptw_pkg: shared constants, configuration register codes and the
// command/status structs that join the pre/post-trigger capture controller and datapath.
// No dependencies.
package pptw_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int SAMPLE_W   = 16;
	localparam int ADDR_W     = $clog2(MAX_WINDOW);
	localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
	localparam int CNT_W      = 32;
	localparam int TS_W       = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LEN_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRE_LENGTH  = 2'd0,
		CFG_POST_LENGTH = 2'd1,
		CFG_ENABLE      = 2'd2
	} cfg_index_t;

	// controller -> datapath
	typedef struct packed {
		logic take;      // request accepted this cycle
		logic stat_ld;   // load a status result into stage 1
		logic copy_end;  // status load closes a ring copy (trigger taken)
		logic copy_rd;   // read one ring entry for the window copy
		logic emit_rd;   // read one window entry into stage 1
	} pptw_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic s1_free;   // stage 1 can be loaded this cycle
		logic trig_copy; // request is a taken trigger with a nonzero pre length
		logic complete;  // request is the sample that completes a window
		logic copy_last; // current ring read is the final one
		logic emit_last; // current window read is the final one
	} pptw_stat_t;

endpackage

[src/pptw_if.sv]
// pptw_in_if / pptw_out_if: valid/ready channels for capture requests and results.
// Depends on pptw_pkg.
interface pptw_in_if;
	logic                           valid;
	logic                           ready;
	logic                           action;
	logic [pptw_pkg::SAMPLE_W-1:0]  sample_value;
	logic [pptw_pkg::TS_W-1:0]      timestamp;

	modport source (output valid, action, sample_value, timestamp, input ready);
	modport sink   (input valid, action, sample_value, timestamp, output ready);
endinterface

interface pptw_out_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic                           accepted;
	logic                           busy_capturing;
	logic [pptw_pkg::SAMPLE_W-1:0]  window_sample;
	logic                           last_of_window;
	logic [pptw_pkg::CNT_W-1:0]     window_id;
	logic [pptw_pkg::LEN_W-1:0]     pre_part;
	logic [pptw_pkg::TS_W-1:0]      elapsed_time;
	logic [pptw_pkg::CNT_W-1:0]     dropped_samples;
	logic [pptw_pkg::CNT_W-1:0]     dropped_triggers;
	logic [pptw_pkg::CNT_W-1:0]     finished_windows;

	modport source (output valid, kind, accepted, busy_capturing, window_sample,
		last_of_window, window_id, pre_part, elapsed_time, dropped_samples,
		dropped_triggers, finished_windows, input ready);
	modport sink   (input valid, kind, accepted, busy_capturing, window_sample,
		last_of_window, window_id, pre_part, elapsed_time, dropped_samples,
		dropped_triggers, finished_windows, output ready);
endinterface

[src/pptw_ctrl.sv]
// pptw_ctrl: sequencing state machine for request intake, ring copy and window emission.
// Depends on pptw_pkg.
module pptw_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pptw_pkg::pptw_stat_t  st,
	output pptw_pkg::pptw_cmd_t   cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_COPY,
		S_COPY_END,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = st.s1_free;
				cmd.take = in_valid & st.s1_free;
				if (cmd.take) begin
					if (st.trig_copy) begin
						state_d = S_COPY;
					end else if (st.complete) begin
						state_d = S_EMIT;
					end else begin
						cmd.stat_ld = 1'b1;
					end
				end
			end
			S_COPY: begin
				cmd.copy_rd = 1'b1;
				if (st.copy_last) begin
					state_d = S_COPY_END;
				end
			end
			S_COPY_END: begin
				if (st.s1_free) begin
					cmd.stat_ld  = 1'b1;
					cmd.copy_end = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_EMIT: begin
				if (st.s1_free) begin
					cmd.emit_rd = 1'b1;
					if (st.emit_last) begin
						state_d = S_IDLE;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[src/pptw_dp.sv]
// pptw_dp: capture datapath: history ring, window store, cursors, counters,
// configuration registers and the two-stage result path. Depends on pptw_pkg, pptw_if.
module pptw_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_action,
	input  logic [pptw_pkg::SAMPLE_W-1:0]     in_sample,
	input  logic [pptw_pkg::TS_W-1:0]         in_ts,
	input  logic                              cfg_we,
	input  logic [pptw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pptw_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  pptw_pkg::pptw_cmd_t               cmd,
	output pptw_pkg::pptw_stat_t              st,
	pptw_out_if.source                        res
);

	localparam int LW = pptw_pkg::LEN_W;
	localparam int AW = pptw_pkg::ADDR_W;
	localparam int SW = pptw_pkg::SAMPLE_W;
	localparam int CW = pptw_pkg::CNT_W;
	localparam int TW = pptw_pkg::TS_W;
	localparam int MW = pptw_pkg::MAX_WINDOW;

	// configuration and architectural state
	logic [LW-1:0] reg_pre_q, reg_post_q, act_pre_q, act_post_q;
	logic          configured_q, capture_q;
	logic [AW-1:0] wp_q;
	logic [LW-1:0] post_col_q;
	logic [CW-1:0] next_id_q, sdrop_q, tdrop_q, done_q;
	logic [TW-1:0] trig_time_q;
	logic [MW-1:0] ring_vld_q;

	// copy and emission cursors
	logic [AW-1:0] rp_q, copy_widx_q, emit_idx_q;
	logic [LW-1:0] copy_cnt_q;
	logic          copy_wr_s1;
	logic [CW-1:0] win_id_q;
	logic [TW-1:0] elapsed_q;

	// memories
	logic [SW-1:0] ring_mem [MW];
	logic [SW-1:0] win_mem  [MW];
	logic [SW-1:0] ring_rdata_s1, win_rdata_s1;
	logic          ring_rvld_s1;

	// result stage 1 and output register
	logic          res_valid_s1, kind_s1, acc_s1, busy_s1, last_s1;
	logic [CW-1:0] id_s1, sdrop_s1, tdrop_s1, done_s1;
	logic [LW-1:0] pre_s1;
	logic [TW-1:0] elapsed_s1;
	logic          out_valid_q, out_kind_q, out_acc_q, out_busy_q, out_last_q;
	logic [SW-1:0] out_sample_q;
	logic [CW-1:0] out_id_q, out_sdrop_q, out_tdrop_q, out_done_q;
	logic [LW-1:0] out_pre_q;
	logic [TW-1:0] out_elapsed_q;

	// request decode
	logic          trig_ok, trig_drop, samp_drop, samp_ok, post_wr, complete, acc_now;
	logic          pre_nz, capture_nx, take_ok;
	logic [LW-1:0] post_col_inc, total, wp_inc, rp_inc;
	logic [CW-1:0] sdrop_nx, tdrop_nx, done_nx;
	logic [LW:0]   cfg_sum;
	logic          enable_ok;
	logic          s1_adv, s1_free, s1_ld;
	logic          win_we;
	logic [AW-1:0] win_wa;
	logic [SW-1:0] win_wd;

	assign pre_nz       = (act_pre_q != '0);
	assign trig_ok      = in_action & configured_q & ~capture_q;
	assign trig_drop    = in_action & configured_q & capture_q;
	assign samp_drop    = ~in_action & ~configured_q;
	assign samp_ok      = ~in_action & configured_q;
	assign post_wr      = samp_ok & capture_q & (post_col_q < act_post_q);
	assign post_col_inc = post_col_q + LW'(1);
	assign complete     = post_wr & (post_col_inc == act_post_q);
	assign acc_now      = trig_ok | samp_ok;
	assign take_ok      = cmd.take & samp_ok;

	assign capture_nx = cmd.take ? ((capture_q & ~complete) | trig_ok) : capture_q;
	assign sdrop_nx   = sdrop_q + CW'(cmd.take & samp_drop);
	assign tdrop_nx   = tdrop_q + CW'(cmd.take & trig_drop);
	assign done_nx    = done_q + CW'(cmd.take & complete);

	assign total  = act_pre_q + act_post_q;
	assign wp_inc = LW'(wp_q) + LW'(1);
	assign rp_inc = LW'(rp_q) + LW'(1);

	assign cfg_sum   = (LW+1)'(reg_pre_q) + (LW+1)'(reg_post_q);
	assign enable_ok = cfg_data[0] && ((reg_pre_q | reg_post_q) != '0)
		&& (cfg_sum <= (LW+1)'(MW));

	assign s1_adv  = res_valid_s1 & (~out_valid_q | res.ready);
	assign s1_free = ~res_valid_s1 | s1_adv;
	assign s1_ld   = cmd.stat_ld | cmd.emit_rd;

	assign st.s1_free   = s1_free;
	assign st.trig_copy = trig_ok & pre_nz;
	assign st.complete  = complete;
	assign st.copy_last = (copy_cnt_q == act_pre_q - LW'(1));
	assign st.emit_last = (LW'(emit_idx_q) == total - LW'(1));

	// single window write port: ring copy or post-trigger sample
	always_comb begin
		win_we = 1'b0;
		win_wa = copy_widx_q;
		win_wd = ring_rvld_s1 ? ring_rdata_s1 : '0;
		if (copy_wr_s1) begin
			win_we = 1'b1;
		end else if (take_ok && post_wr) begin
			win_we = 1'b1;
			win_wa = AW'(act_pre_q + post_col_q);
			win_wd = in_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_pre_q    <= '0;
			reg_post_q   <= '0;
			act_pre_q    <= '0;
			act_post_q   <= '0;
			configured_q <= 1'b0;
			capture_q    <= 1'b0;
			wp_q         <= '0;
			post_col_q   <= '0;
			next_id_q    <= '0;
			trig_time_q  <= '0;
			sdrop_q      <= '0;
			tdrop_q      <= '0;
			done_q       <= '0;
			ring_vld_q   <= '0;
			rp_q         <= '0;
			copy_cnt_q   <= '0;
			copy_widx_q  <= '0;
			copy_wr_s1   <= 1'b0;
			emit_idx_q   <= '0;
			res_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			copy_wr_s1   <= cmd.copy_rd;
			res_valid_s1 <= s1_ld | (res_valid_s1 & ~s1_adv);
			out_valid_q  <= s1_adv | (out_valid_q & ~res.ready);
			if (cfg_we) begin
				unique case (pptw_pkg::cfg_index_t'(cfg_index))
					pptw_pkg::CFG_PRE_LENGTH:  reg_pre_q  <= cfg_data[LW-1:0];
					pptw_pkg::CFG_POST_LENGTH: reg_post_q <= cfg_data[LW-1:0];
					pptw_pkg::CFG_ENABLE: begin
						if (!cfg_data[0]) begin
							configured_q <= 1'b0;
							capture_q    <= 1'b0;
						end else if (enable_ok) begin
							act_pre_q    <= reg_pre_q;
							act_post_q   <= reg_post_q;
							configured_q <= 1'b1;
							capture_q    <= 1'b0;
							wp_q         <= '0;
							post_col_q   <= '0;
							next_id_q    <= '0;
							trig_time_q  <= '0;
							sdrop_q      <= '0;
							tdrop_q      <= '0;
							done_q       <= '0;
							ring_vld_q   <= '0;
						end
					end
					default: ;
				endcase
			end else begin
				capture_q <= capture_nx;
				sdrop_q   <= sdrop_nx;
				tdrop_q   <= tdrop_nx;
				done_q    <= done_nx;
				if (cmd.take && trig_ok) begin
					post_col_q  <= '0;
					trig_time_q <= in_ts;
					rp_q        <= wp_q;
					copy_cnt_q  <= '0;
					copy_widx_q <= '0;
				end
				if (take_ok && pre_nz) begin
					ring_vld_q[wp_q] <= 1'b1;
					wp_q <= (wp_inc >= act_pre_q) ? '0 : wp_inc[AW-1:0];
				end
				if (take_ok && post_wr) begin
					post_col_q <= post_col_inc;
				end
				if (cmd.take && complete) begin
					next_id_q  <= next_id_q + CW'(1);
					emit_idx_q <= '0;
				end
				if (cmd.copy_rd) begin
					rp_q       <= (rp_inc >= act_pre_q) ? '0 : rp_inc[AW-1:0];
					copy_cnt_q <= copy_cnt_q + LW'(1);
				end
				if (copy_wr_s1) begin
					copy_widx_q <= copy_widx_q + AW'(1);
				end
				if (cmd.emit_rd) begin
					emit_idx_q <= emit_idx_q + AW'(1);
				end
			end
		end
	end

	// memories and payload registers
	always_ff @(posedge clk) begin
		if (take_ok && pre_nz) begin
			ring_mem[wp_q] <= in_sample;
		end
		if (cmd.copy_rd) begin
			ring_rdata_s1 <= ring_mem[rp_q];
			ring_rvld_s1  <= ring_vld_q[rp_q];
		end
		if (win_we) begin
			win_mem[win_wa] <= win_wd;
		end
		if (cmd.emit_rd) begin
			win_rdata_s1 <= win_mem[emit_idx_q];
		end
		if (cmd.take && complete) begin
			win_id_q  <= next_id_q;
			elapsed_q <= in_ts - trig_time_q;
		end
		if (s1_ld) begin
			kind_s1    <= cmd.emit_rd;
			acc_s1     <= cmd.emit_rd | cmd.copy_end | (cmd.take & acc_now);
			busy_s1    <= ~cmd.emit_rd & configured_q & capture_nx;
			last_s1    <= cmd.emit_rd & st.emit_last;
			id_s1      <= cmd.emit_rd ? win_id_q : '0;
			pre_s1     <= cmd.emit_rd ? act_pre_q : '0;
			elapsed_s1 <= cmd.emit_rd ? elapsed_q : '0;
			sdrop_s1   <= sdrop_nx;
			tdrop_s1   <= tdrop_nx;
			done_s1    <= done_nx;
		end
		if (s1_adv) begin
			out_kind_q    <= kind_s1;
			out_acc_q     <= acc_s1;
			out_busy_q    <= busy_s1;
			out_sample_q  <= kind_s1 ? win_rdata_s1 : '0;
			out_last_q    <= last_s1;
			out_id_q      <= id_s1;
			out_pre_q     <= pre_s1;
			out_elapsed_q <= elapsed_s1;
			out_sdrop_q   <= sdrop_s1;
			out_tdrop_q   <= tdrop_s1;
			out_done_q    <= done_s1;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.kind             = out_kind_q;
	assign res.accepted         = out_acc_q;
	assign res.busy_capturing   = out_busy_q;
	assign res.window_sample    = out_sample_q;
	assign res.last_of_window   = out_last_q;
	assign res.window_id        = out_id_q;
	assign res.pre_part         = out_pre_q;
	assign res.elapsed_time     = out_elapsed_q;
	assign res.dropped_samples  = out_sdrop_q;
	assign res.dropped_triggers = out_tdrop_q;
	assign res.finished_windows = out_done_q;

	a_capture_configured: assert property (@(posedge clk) disable iff (!arst_n)
		capture_q |-> configured_q)
		else $error("capture running while unconfigured");

	a_post_bound: assert property (@(posedge clk) disable iff (!arst_n)
		post_col_q <= act_post_q)
		else $error("post-trigger count beyond post length");

	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(act_pre_q != '0) |-> (LW'(wp_q) < act_pre_q))
		else $error("ring write position beyond pre length");

	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.stat_ld || cmd.emit_rd) |-> s1_free)
		else $error("result stage overwritten");

endmodule

[src/pre_post_trigger_window_capture_top.sv]
// A status result is registered in stage 1 and then in the output register ahead of out_res.
// Throughput: one request per cycle while out_res is ready and each causes one status result.
// A taken trigger with pre length P > 0 holds off input during the ring copy (one read port).
// A completing sample emits pre+post results, one per cycle while out_res is ready (window read port).
// Reset: arst_n asynchronous; clears control state and counters, ring reads zero via
// per-entry valid bits; the window store has no reset. No clearing pass.
module pre_post_trigger_window_capture_top (
	input  logic                              clk,
	input  logic                              arst_n,
	pptw_in_if.sink                           in_req,
	pptw_out_if.source                        out_res,
	input  logic                              cfg_we,
	input  logic [pptw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pptw_pkg::CFG_DATA_W-1:0]   cfg_data
);

	pptw_pkg::pptw_cmd_t  cmd;
	pptw_pkg::pptw_stat_t st;
	logic                 in_ready;

	assign in_req.ready = in_ready;

	pptw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_req.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	pptw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_action (in_req.action),
		.in_sample (in_req.sample_value),
		.in_ts     (in_req.timestamp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.res       (out_res)
	);

endmodule

[verif/pre_post_trigger_window_capture_top_test.sv]
`timescale 1ns / 100ps
// Testbench for pre_post_trigger_window_capture_top: directed and random sample/trigger requests,
// each result checked field by field against an in-bench model of the pre/post-trigger capture.
// Depends on pptw_pkg, pptw_in_if / pptw_out_if and the RTL top level.
module pre_post_trigger_window_capture_top_test;

	localparam int SW = pptw_pkg::SAMPLE_W;
	localparam int LW = pptw_pkg::LEN_W;
	localparam int DW = pptw_pkg::CFG_DATA_W;

	typedef struct packed {
		logic                          action;
		logic [pptw_pkg::SAMPLE_W-1:0] sample_value;
		logic [pptw_pkg::TS_W-1:0]     timestamp;
	} capture_req_t;

	typedef struct packed {
		logic                          kind;
		logic                          accepted;
		logic                          busy_capturing;
		logic [pptw_pkg::SAMPLE_W-1:0] window_sample;
		logic                          last_of_window;
		logic [pptw_pkg::CNT_W-1:0]    window_id;
		logic [pptw_pkg::LEN_W-1:0]    pre_part;
		logic [pptw_pkg::TS_W-1:0]     elapsed_time;
		logic [pptw_pkg::CNT_W-1:0]    dropped_samples;
		logic [pptw_pkg::CNT_W-1:0]    dropped_triggers;
		logic [pptw_pkg::CNT_W-1:0]    finished_windows;
	} capture_res_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [pptw_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pptw_pkg::CFG_DATA_W-1:0] cfg_data;

	pptw_in_if  in_req();
	pptw_out_if out_res();

	pre_post_trigger_window_capture_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_req(in_req),
		.out_res(out_res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// capture model state
	logic [pptw_pkg::SAMPLE_W-1:0] hist_ring [pptw_pkg::MAX_WINDOW];
	logic [pptw_pkg::SAMPLE_W-1:0] win_buf [pptw_pkg::MAX_WINDOW];
	int                            hist_wp;
	int                            post_cnt;
	bit                            capturing;
	bit                            armed;
	logic [pptw_pkg::CNT_W-1:0]    win_seq;
	logic [pptw_pkg::TS_W-1:0]     trig_ts;
	logic [pptw_pkg::CNT_W-1:0]    smp_drops;
	logic [pptw_pkg::CNT_W-1:0]    trig_drops;
	logic [pptw_pkg::CNT_W-1:0]    win_done;
	int                            reg_pre_len;
	int                            reg_post_len;
	int                            live_pre;
	int                            live_post;

	capture_res_t due_results[$];
	capture_req_t req_backlog[$];
	int           mismatch_cnt;
	int           res_cnt;
	int           sent_cnt;
	bit           req_hs;
	bit           calm;
	int           gap_left;
	int           rdy_left;
	logic [pptw_pkg::TS_W-1:0] ts_clock;

	task report_mismatch(string what);
		mismatch_cnt++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	task check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("result %0d %s: got %0h expected %0h",
				res_cnt, name, got, want));
		end
	endtask

	function void clear_capture();
		for (int i = 0; i < pptw_pkg::MAX_WINDOW; i++) begin
			hist_ring[i] = '0;
			win_buf[i] = '0;
		end
		hist_wp = 0;
		post_cnt = 0;
		capturing = 1'b0;
		win_seq = '0;
		trig_ts = '0;
		smp_drops = '0;
		trig_drops = '0;
		win_done = '0;
	endfunction

	function void apply_setting(pptw_pkg::cfg_index_t idx, logic [pptw_pkg::CFG_DATA_W-1:0] val);
		unique case (idx)
			pptw_pkg::CFG_PRE_LENGTH: reg_pre_len = int'(val);
			pptw_pkg::CFG_POST_LENGTH: reg_post_len = int'(val);
			pptw_pkg::CFG_ENABLE: begin
				if (!val[0]) begin
					armed = 1'b0;
					capturing = 1'b0;
				end else if ((reg_pre_len != 0 || reg_post_len != 0) &&
						reg_pre_len + reg_post_len <= pptw_pkg::MAX_WINDOW) begin
					clear_capture();
					live_pre = reg_pre_len;
					live_post = reg_post_len;
					armed = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	function capture_res_t status_result(logic acc);
		capture_res_t r;
		r = '0;
		r.accepted = acc;
		r.busy_capturing = armed && capturing;
		r.dropped_samples = smp_drops;
		r.dropped_triggers = trig_drops;
		r.finished_windows = win_done;
		return r;
	endfunction

	function void predict_capture(capture_req_t q);
		capture_res_t r;
		logic acc;
		int total;
		if (q.action) begin
			acc = 1'b0;
			if (armed && capturing) begin
				trig_drops++;
			end else if (armed) begin
				for (int i = 0; i < live_pre; i++)
					win_buf[i] = hist_ring[(hist_wp + i) % live_pre];
				post_cnt = 0;
				capturing = 1'b1;
				trig_ts = q.timestamp;
				acc = 1'b1;
			end
			due_results.push_back(status_result(acc));
			return;
		end
		if (!armed) begin
			smp_drops++;
			due_results.push_back(status_result(1'b0));
			return;
		end
		if (live_pre != 0) begin
			hist_ring[hist_wp] = q.sample_value;
			hist_wp = (hist_wp + 1 >= live_pre) ? 0 : hist_wp + 1;
		end
		if (capturing && post_cnt < live_post) begin
			win_buf[live_pre + post_cnt] = q.sample_value;
			post_cnt++;
			if (post_cnt == live_post) begin
				total = live_pre + live_post;
				capturing = 1'b0;
				win_done++;
				for (int i = 0; i < total; i++) begin
					r = status_result(1'b1);
					r.kind = 1'b1;
					r.window_sample = win_buf[i];
					r.last_of_window = (i == total - 1);
					r.window_id = win_seq;
					r.pre_part = LW'(live_pre);
					r.elapsed_time = q.timestamp - trig_ts;
					due_results.push_back(r);
				end
				win_seq++;
				return;
			end
		end
		due_results.push_back(status_result(1'b1));
	endfunction

	// mostly short gaps, a few long ones, none in calm phases
	function int pick_gap();
		int p;
		if (calm)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 10);
		return $urandom_range(15, 30);
	endfunction

	function logic [pptw_pkg::TS_W-1:0] next_ts();
		if ($urandom_range(0, 9) == 0)
			ts_clock = $urandom();
		else
			ts_clock = ts_clock + $urandom_range(1, 20);
		return ts_clock;
	endfunction

	function void send(logic action, logic [pptw_pkg::SAMPLE_W-1:0] value,
			logic [pptw_pkg::TS_W-1:0] stamp);
		capture_req_t q;
		q.action = action;
		q.sample_value = value;
		q.timestamp = stamp;
		req_backlog.push_back(q);
		sent_cnt++;
	endfunction

	task automatic write_reg(pptw_pkg::cfg_index_t idx, logic [pptw_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		apply_setting(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (req_backlog.size() != 0 || in_req.valid || due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic pick_setting(int phase);
		int sel;
		int pre;
		int post;
		sel = $urandom_range(0, 19);
		if (phase % 3 == 1 && phase / 3 < 3)
			sel = 100 + phase / 3;
		calm = ($urandom_range(0, 4) == 0);
		pre = $urandom_range(0, 8);
		post = $urandom_range(0, 8);
		unique case (sel)
			100: begin
				pre = pptw_pkg::MAX_WINDOW;
				post = 0;
			end
			101: begin
				pre = 0;
				post = pptw_pkg::MAX_WINDOW;
			end
			102: begin
				pre = pptw_pkg::MAX_WINDOW / 2;
				post = pptw_pkg::MAX_WINDOW / 2;
			end
			0: begin
				pre = $urandom_range(1, 127);
				post = $urandom_range(pptw_pkg::MAX_WINDOW, 127);
			end
			1: begin
				pre = 0;
				post = 0;
			end
			2: begin
				write_reg(pptw_pkg::CFG_ENABLE, DW'(0));
				return;
			end
			3: begin
				// lengths only, picked up at the next enable
				write_reg(pptw_pkg::CFG_PRE_LENGTH, DW'(pre));
				write_reg(pptw_pkg::CFG_POST_LENGTH, DW'(post));
				return;
			end
			default: ;
		endcase
		write_reg(pptw_pkg::CFG_PRE_LENGTH, DW'(pre));
		write_reg(pptw_pkg::CFG_POST_LENGTH, DW'(post));
		write_reg(pptw_pkg::CFG_ENABLE, DW'(1));
		repeat (2) @(negedge clk);
	endtask

	task automatic run_sequence();
		int p;
		int m;
		p = $urandom_range(0, 99);
		if (!armed || p < 10) begin
			repeat ($urandom_range(1, 6))
				send(1'($urandom_range(0, 1)), SW'($urandom()), next_ts());
			return;
		end
		repeat ($urandom_range(0, live_pre + 2))
			send(1'b0, SW'($urandom()), next_ts());
		send(1'b1, SW'($urandom()), next_ts());
		m = (p < 25) ? $urandom_range(0, live_post) : live_post;
		for (int i = 0; i < m; i++) begin
			if ($urandom_range(0, 9) == 0)
				send(1'b1, SW'($urandom()), next_ts());
			send(1'b0, SW'($urandom()), next_ts());
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// request driver
	always @(negedge clk) begin
		capture_req_t nxt;
		if (!arst_n) begin
			in_req.valid <= 1'b0;
		end else if (!in_req.valid || req_hs) begin
			if (gap_left > 0) begin
				in_req.valid <= 1'b0;
				gap_left--;
			end else if (req_backlog.size() > 0) begin
				nxt = req_backlog.pop_front();
				in_req.valid <= 1'b1;
				in_req.action <= nxt.action;
				in_req.sample_value <= nxt.sample_value;
				in_req.timestamp <= nxt.timestamp;
				gap_left = pick_gap();
			end else begin
				in_req.valid <= 1'b0;
			end
		end
	end

	// result backpressure
	always @(negedge clk) begin
		int stall;
		if (!arst_n) begin
			out_res.ready <= 1'b0;
		end else if (rdy_left > 0) begin
			rdy_left--;
		end else if (out_res.ready) begin
			stall = pick_gap();
			if (stall > 0) begin
				out_res.ready <= 1'b0;
				rdy_left = stall - 1;
			end else begin
				rdy_left = $urandom_range(0, 20);
			end
		end else begin
			out_res.ready <= 1'b1;
			rdy_left = $urandom_range(0, 40);
		end
	end

	// monitor: results first, then the request taken at this edge
	always @(posedge clk) begin
		capture_res_t want;
		capture_req_t got;
		req_hs = 1'b0;
		if (arst_n) begin
			if (out_res.valid && out_res.ready) begin
				if (due_results.size() == 0) begin
					report_mismatch($sformatf("result %0d with nothing expected", res_cnt));
				end else begin
					want = due_results.pop_front();
					check_field("kind", 32'(out_res.kind), 32'(want.kind));
					check_field("accepted", 32'(out_res.accepted), 32'(want.accepted));
					check_field("busy_capturing", 32'(out_res.busy_capturing),
						32'(want.busy_capturing));
					check_field("window_sample", 32'(out_res.window_sample),
						32'(want.window_sample));
					check_field("last_of_window", 32'(out_res.last_of_window),
						32'(want.last_of_window));
					check_field("window_id", out_res.window_id, want.window_id);
					check_field("pre_part", 32'(out_res.pre_part), 32'(want.pre_part));
					check_field("elapsed_time", out_res.elapsed_time, want.elapsed_time);
					check_field("dropped_samples", out_res.dropped_samples,
						want.dropped_samples);
					check_field("dropped_triggers", out_res.dropped_triggers,
						want.dropped_triggers);
					check_field("finished_windows", out_res.finished_windows,
						want.finished_windows);
				end
				res_cnt++;
			end
			if (in_req.valid && in_req.ready) begin
				req_hs = 1'b1;
				got.action = in_req.action;
				got.sample_value = in_req.sample_value;
				got.timestamp = in_req.timestamp;
				predict_capture(got);
			end
		end
	end

	initial begin
		int base;
		int phase;
		int n;
		int guard;
		in_req.valid = 1'b0;
		in_req.action = 1'b0;
		in_req.sample_value = '0;
		in_req.timestamp = '0;
		out_res.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = pptw_pkg::CFG_PRE_LENGTH;
		cfg_data = '0;
		arst_n = 1'b0;
		clear_capture();
		ts_clock = $urandom();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// unconfigured: samples dropped, trigger refused
		send(1'b0, 16'hFFFF, 32'hFFFF_FFFF);
		send(1'b0, 16'h0000, 32'h0000_0000);
		send(1'b1, 16'h1234, 32'h0000_0010);
		drain();
		// enables that must be ignored
		write_reg(pptw_pkg::CFG_PRE_LENGTH, DW'(0));
		write_reg(pptw_pkg::CFG_POST_LENGTH, DW'(0));
		write_reg(pptw_pkg::CFG_ENABLE, DW'(1));
		send(1'b0, 16'h00FF, 32'h0000_0020);
		drain();
		write_reg(pptw_pkg::CFG_PRE_LENGTH, DW'(127));
		write_reg(pptw_pkg::CFG_POST_LENGTH, DW'(127));
		write_reg(pptw_pkg::CFG_ENABLE, DW'(1));
		send(1'b0, 16'hFF00, 32'h0000_0030);
		drain();
		write_reg(pptw_pkg::CFG_PRE_LENGTH, DW'(40));
		write_reg(pptw_pkg::CFG_POST_LENGTH, DW'(25));
		write_reg(pptw_pkg::CFG_ENABLE, DW'(1));
		send(1'b0, 16'h0F0F, 32'h0000_0040);
		drain();
		// trigger on a fresh ring, second trigger dropped, elapsed wraps
		write_reg(pptw_pkg::CFG_PRE_LENGTH, DW'(2));
		write_reg(pptw_pkg::CFG_POST_LENGTH, DW'(3));
		write_reg(pptw_pkg::CFG_ENABLE, DW'(1));
		send(1'b1, 16'h0000, 32'hFFFF_FFF0);
		send(1'b0, 16'h8000, 32'hFFFF_FFF8);
		send(1'b1, 16'hFFFF, 32'hFFFF_FFFA);
		send(1'b0, 16'h7FFF, 32'hFFFF_FFFE);
		send(1'b0, 16'h5555, 32'h0000_0004);
		drain();
		// length written while armed waits for the next enable
		write_reg(pptw_pkg::CFG_PRE_LENGTH, DW'(5));
		send(1'b0, 16'hAAAA, 32'h0000_0100);
		send(1'b0, 16'hF0F0, 32'h0000_0101);
		send(1'b1, 16'h0000, 32'h0000_0102);
		send(1'b0, 16'h1111, 32'h0000_0103);
		send(1'b0, 16'h2222, 32'h0000_0104);
		send(1'b0, 16'h3333, 32'h0000_0108);
		drain();
		write_reg(pptw_pkg::CFG_ENABLE, DW'(0));
		send(1'b1, 16'h0000, 32'h0000_0200);
		send(1'b0, 16'h4444, 32'h0000_0201);
		drain();
		// zero post length: capture never completes
		write_reg(pptw_pkg::CFG_POST_LENGTH, DW'(0));
		write_reg(pptw_pkg::CFG_ENABLE, DW'(1));
		send(1'b0, 16'h6666, 32'h0000_0300);
		send(1'b1, 16'h0000, 32'h0000_0301);
		send(1'b0, 16'h7777, 32'h0000_0302);
		send(1'b1, 16'h0000, 32'h0000_0303);
		drain();
		// zero pre length
		write_reg(pptw_pkg::CFG_PRE_LENGTH, DW'(0));
		write_reg(pptw_pkg::CFG_POST_LENGTH, DW'(2));
		write_reg(pptw_pkg::CFG_ENABLE, DW'(1));
		send(1'b1, 16'h0000, 32'h0000_0400);
		send(1'b0, 16'h9999, 32'h0000_0401);
		send(1'b0, 16'hCCCC, 32'h0000_0405);

		base = sent_cnt;
		phase = 0;
		while (sent_cnt - base < 300) begin
			drain();
			pick_setting(phase);
			phase++;
			n = (live_pre + live_post > 20) ? 1 : $urandom_range(2, 5);
			repeat (n) run_sequence();
		end

		guard = 0;
		while ((req_backlog.size() != 0 || in_req.valid || due_results.size() != 0) &&
				guard < 500000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (due_results.size() != 0 || req_backlog.size() != 0)
			report_mismatch($sformatf("%0d results still expected, %0d requests not taken",
				due_results.size(), req_backlog.size()));
		if (mismatch_cnt == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[pre_post_trigger_window_capture_top.f]
src/pptw_pkg.sv
src/pptw_if.sv
src/pptw_ctrl.sv
src/pptw_dp.sv
src/pre_post_trigger_window_capture_top.sv
verif/pre_post_trigger_window_capture_top_test.sv
